// File: rtl/core/link_handshake_sequencer_assert.svh
// Assertion macros used by the link handshake sequencer core.
`ifndef LINK_HANDSHAKE_SEQUENCER_ASSERT_SVH
`define LINK_HANDSHAKE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("link handshake sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("link handshake sequencer: next-cycle check failed");

`endif

// File: rtl/core/lhs_pkg.sv
// Package with the types, codes and step tables of the link handshake sequencer.
`default_nettype none
package lhs_pkg;

	localparam int unsigned STEP_W  = 3;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CFG_W   = 16;

	localparam logic [COUNT_W-1:0] SWAP_LIMIT_RESET = 16'd4000;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;
	localparam logic [STEP_W-1:0]  STEP_SLOTS       = 3'd5;

	localparam logic CMD_START    = 1'b0;
	localparam logic CMD_EXCHANGE = 1'b1;

	localparam logic CFG_GEN_MODE   = 1'b0;
	localparam logic CFG_SWAP_LIMIT = 1'b1;

	localparam logic [1:0] PHASE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_ROOM  = 2'd1;
	localparam logic [1:0] PHASE_TABLE = 2'd2;

	localparam logic [1:0] STATUS_BUSY    = 2'd0;
	localparam logic [1:0] STATUS_DONE    = 2'd1;
	localparam logic [1:0] STATUS_NO_GAME = 2'd2;

	localparam logic [1:0] KIND_INDEX = 2'd0;
	localparam logic [1:0] KIND_ROOM  = 2'd1;
	localparam logic [1:0] KIND_ONE   = 2'd2;

	typedef struct packed {
		logic               gen_mode;
		logic [COUNT_W-1:0] swap_limit;
	} lhs_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] send_byte;
		logic [1:0]        status;
		logic              phase_now;
	} lhs_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] send;
		logic [1:0]        kind;
		logic [BYTE_W-1:0] val;
	} lhs_step_t;

	function automatic lhs_step_t step_entry(input logic gen, input logic table_phase,
			input logic [STEP_W-1:0] step);
		lhs_step_t e;
		e = '{send: 8'h00, kind: KIND_ONE, val: 8'h00};
		unique case ({gen, table_phase, step})
			{1'b0, 1'b0, 3'd0}: e = '{send: 8'h01, kind: KIND_INDEX, val: 8'h00};
			{1'b0, 1'b0, 3'd1}: e = '{send: 8'h60, kind: KIND_ROOM,  val: 8'h00};
			{1'b0, 1'b0, 3'd2}: e = '{send: 8'hD0, kind: KIND_ROOM,  val: 8'h00};
			{1'b0, 1'b0, 3'd3}: e = '{send: 8'hD4, kind: KIND_INDEX, val: 8'h00};
			{1'b0, 1'b1, 3'd0}: e = '{send: 8'h60, kind: KIND_INDEX, val: 8'h00};
			{1'b0, 1'b1, 3'd1}: e = '{send: 8'h60, kind: KIND_ONE,   val: 8'hFD};
			{1'b1, 1'b0, 3'd0}: e = '{send: 8'h01, kind: KIND_ONE,   val: 8'h61};
			{1'b1, 1'b0, 3'd1}: e = '{send: 8'h61, kind: KIND_ONE,   val: 8'hD1};
			{1'b1, 1'b0, 3'd2}: e = '{send: 8'hD1, kind: KIND_ONE,   val: 8'h00};
			{1'b1, 1'b0, 3'd3}: e = '{send: 8'h00, kind: KIND_ONE,   val: 8'hFE};
			{1'b1, 1'b0, 3'd4}: e = '{send: 8'hFE, kind: KIND_ONE,   val: 8'hFE};
			{1'b1, 1'b1, 3'd0}: e = '{send: 8'h75, kind: KIND_ONE,   val: 8'h75};
			{1'b1, 1'b1, 3'd1}: e = '{send: 8'h75, kind: KIND_ONE,   val: 8'h00};
			{1'b1, 1'b1, 3'd2}: e = '{send: 8'h76, kind: KIND_ONE,   val: 8'hFD};
			default:            e = '{send: 8'h00, kind: KIND_ONE,   val: 8'h00};
		endcase
		return e;
	endfunction

	function automatic logic [STEP_W-1:0] step_total(input logic gen, input logic table_phase);
		logic [STEP_W-1:0] t;
		unique case ({gen, table_phase})
			2'b00:   t = 3'd4;
			2'b01:   t = 3'd2;
			2'b10:   t = 3'd5;
			default: t = 3'd3;
		endcase
		return t;
	endfunction

	function automatic logic step_accepts(input lhs_step_t e, input logic [BYTE_W-1:0] b);
		logic ok;
		unique case (e.kind)
			KIND_INDEX: ok = (b >= 8'h60 && b <= 8'h65) || b == 8'h6F;
			KIND_ROOM:  ok = b >= 8'hD0 && b <= 8'hD4;
			default:    ok = b == e.val;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/lhs_in_if.sv
// Request channel carrying commands and received bytes into the sequencer.
`default_nettype none
interface lhs_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [lhs_pkg::BYTE_W-1:0] recv_byte;

	modport source (output valid, output cmd, output recv_byte, input ready);
	modport sink (input valid, input cmd, input recv_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lhs_out_if.sv
// Result channel carrying the next byte to send, status and phase.
`default_nettype none
interface lhs_out_if;
	logic                       valid;
	logic                       ready;
	logic [lhs_pkg::BYTE_W-1:0] send_byte;
	logic [1:0]                 status;
	logic                       phase_now;

	modport source (output valid, output send_byte, output status, output phase_now,
		input ready);
	modport sink (input valid, input send_byte, input status, input phase_now,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/link_handshake_sequencer.sv
// Top level of the link handshake sequencer.
//   channel   direction  carries
//   in        sink       cmd, recv_byte
//   out       source     send_byte, status, phase_now
//   cfg       write      cfg_wr_en, cfg_index, cfg_data
// Each request is stepped by the combinational step logic and the result is
// registered, so one request is taken every cycle while results are drained.
// A result appears in the cycle after its request is accepted.
// in.ready falls only while a held result is not taken by the output side.
// Reset clears the handshake state and the output valid and sets the configuration to its reset values.
`default_nettype none
module link_handshake_sequencer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	lhs_in_if.sink                          in,
	lhs_out_if.source                       out,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_index,
	input  wire logic [lhs_pkg::CFG_W-1:0]  cfg_data
);

	lhs_pkg::lhs_cfg_t     cfg;
	lhs_pkg::lhs_result_t  result;
	logic                  space;
	logic                  accept;

	assign in.ready = space;
	assign accept   = in.valid && space;

	lhs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lhs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (in.cmd),
		.recv_byte (in.recv_byte),
		.cfg       (cfg),
		.result    (result)
	);

	lhs_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.result (result),
		.space  (space),
		.out    (out)
	);

endmodule
`default_nettype wire

// File: rtl/core/lhs_cfg.sv
// Configuration registers for generation mode and swap limit.
`default_nettype none
module lhs_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic                        index,
	input  wire logic [lhs_pkg::CFG_W-1:0]   data,
	output lhs_pkg::lhs_cfg_t                cfg
);

	logic                          gen_mode_q;
	logic [lhs_pkg::COUNT_W-1:0]   swap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_mode_q   <= 1'b0;
			swap_limit_q <= lhs_pkg::SWAP_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (index)
				lhs_pkg::CFG_GEN_MODE:   gen_mode_q   <= data[0];
				lhs_pkg::CFG_SWAP_LIMIT: swap_limit_q <= data[lhs_pkg::COUNT_W-1:0];
				default:                 gen_mode_q   <= gen_mode_q;
			endcase
		end
	end

	assign cfg.gen_mode   = gen_mode_q;
	assign cfg.swap_limit = swap_limit_q;

endmodule
`default_nettype wire

// File: rtl/core/lhs_core.sv
// Handshake state registers with the combinational step and result logic.
`default_nettype none
module lhs_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic                       cmd,
	input  wire logic [lhs_pkg::BYTE_W-1:0] recv_byte,
	input  lhs_pkg::lhs_cfg_t               cfg,
	output lhs_pkg::lhs_result_t            result
);

	`include "link_handshake_sequencer_assert.svh"

	logic [1:0]                    phase_q, phase_d;
	logic [lhs_pkg::STEP_W-1:0]    step_q, step_d, step_adv, total;
	logic [lhs_pkg::COUNT_W-1:0]   count_q, count_d, count_inc;
	logic [1:0]                    outcome_q, outcome_d;
	logic                          gen_q, gen_d;
	logic                          adv;
	logic [1:0]                    phase_m1;
	lhs_pkg::lhs_step_t            cur_entry, out_entry;

	assign total     = lhs_pkg::step_total(gen_q, phase_q == lhs_pkg::PHASE_TABLE);
	assign cur_entry = lhs_pkg::step_entry(gen_q, phase_q == lhs_pkg::PHASE_TABLE, step_q);
	assign adv       = (step_q < total) && lhs_pkg::step_accepts(cur_entry, recv_byte);
	assign step_adv  = step_q + {2'b00, adv};
	assign count_inc = (count_q == lhs_pkg::COUNT_MAX) ? count_q : count_q + 16'd1;

	always_comb begin
		phase_d   = phase_q;
		step_d    = step_q;
		count_d   = count_q;
		outcome_d = outcome_q;
		gen_d     = gen_q;
		if (cmd == lhs_pkg::CMD_START) begin
			gen_d     = cfg.gen_mode;
			phase_d   = lhs_pkg::PHASE_ROOM;
			step_d    = '0;
			count_d   = '0;
			outcome_d = lhs_pkg::STATUS_BUSY;
		end else if (phase_q != lhs_pkg::PHASE_IDLE && outcome_q == lhs_pkg::STATUS_BUSY) begin
			step_d  = step_adv;
			count_d = count_inc;
			if (count_inc >= cfg.swap_limit) begin
				outcome_d = lhs_pkg::STATUS_NO_GAME;
			end else if (step_adv >= total) begin
				if (phase_q == lhs_pkg::PHASE_ROOM) begin
					phase_d = lhs_pkg::PHASE_TABLE;
					step_d  = '0;
					count_d = '0;
				end else begin
					outcome_d = lhs_pkg::STATUS_DONE;
				end
			end
		end
	end

	assign out_entry = lhs_pkg::step_entry(gen_d, phase_d == lhs_pkg::PHASE_TABLE, step_d);
	assign phase_m1  = phase_d - 2'd1;

	always_comb begin
		if (phase_d == lhs_pkg::PHASE_IDLE) begin
			result.send_byte = '0;
			result.status    = lhs_pkg::STATUS_NO_GAME;
			result.phase_now = 1'b0;
		end else begin
			result.send_byte = (outcome_d == lhs_pkg::STATUS_BUSY && step_d < lhs_pkg::STEP_SLOTS)
				? out_entry.send : '0;
			result.status    = outcome_d;
			result.phase_now = phase_m1[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lhs_pkg::PHASE_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			outcome_q <= lhs_pkg::STATUS_BUSY;
			gen_q     <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			step_q    <= step_d;
			count_q   <= count_d;
			outcome_q <= outcome_d;
			gen_q     <= gen_d;
		end
	end

	`LHS_ASSERT_NEXT(a_start_restarts, clk, arst_n, accept && cmd == lhs_pkg::CMD_START,
		phase_q == lhs_pkg::PHASE_ROOM && step_q == '0 && count_q == '0
		&& outcome_q == lhs_pkg::STATUS_BUSY)
	`LHS_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !accept,
		$stable(phase_q) && $stable(step_q) && $stable(count_q) && $stable(outcome_q))
	`LHS_ASSERT_SAME(a_idle_is_clean, clk, arst_n, phase_q == lhs_pkg::PHASE_IDLE,
		count_q == '0 && outcome_q == lhs_pkg::STATUS_BUSY)

endmodule
`default_nettype wire

// File: rtl/core/lhs_out.sv
// Output register holding one result until the receiving side takes it.
`default_nettype none
module lhs_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  lhs_pkg::lhs_result_t  result,
	output logic                  space,
	lhs_out_if.source             out
);

	logic                  valid_q;
	lhs_pkg::lhs_result_t  data_q;

	assign space = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out.valid     = valid_q;
	assign out.send_byte = data_q.send_byte;
	assign out.status    = data_q.status;
	assign out.phase_now = data_q.phase_now;

endmodule
`default_nettype wire

// File: test/link_handshake_sequencer_tb.sv
// Self-checking testbench for the link handshake sequencer: directed table, then random runs.
module link_handshake_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REQUESTS = 1000;

	typedef struct packed {
		logic [lhs_pkg::BYTE_W-1:0] tx;
		logic [1:0]                 rule;
		logic [lhs_pkg::BYTE_W-1:0] want;
	} link_step_t;

	typedef struct {
		logic                       is_reg;
		logic                       idx;
		logic [lhs_pkg::CFG_W-1:0]  data;
		logic                       cmd;
		logic [lhs_pkg::BYTE_W-1:0] rx;
		logic                       typed;
		lhs_pkg::lhs_result_t       reply;
	} plan_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_BEAT, STALL_HEAVY} stall_kind_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic                      cfg_index;
	logic [lhs_pkg::CFG_W-1:0] cfg_data;

	lhs_in_if  req_ch ();
	lhs_out_if rsp_ch ();

	link_handshake_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (req_ch),
		.out       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic                        gen_sel;
	logic [lhs_pkg::COUNT_W-1:0] limit_sel;
	logic                        gen_held;
	logic [1:0]                  link_phase;
	logic [lhs_pkg::STEP_W-1:0]  link_step_no;
	logic [lhs_pkg::COUNT_W-1:0] swaps;
	logic [1:0]                  verdict;

	lhs_pkg::lhs_result_t due_replies[$];
	plan_row_t            plan[$];
	int                   mismatches;
	int                   requests_sent;
	int                   burst_left;
	stall_kind_t          stall_mode;
	int                   stall_left;
	int                   stall_tick;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic link_step_t link_step(input logic g, input logic tp,
			input logic [lhs_pkg::STEP_W-1:0] s);
		link_step_t e;
		case ({g, tp, s})
			{1'b0, 1'b0, 3'd0}: e = '{tx: 8'h01, rule: lhs_pkg::KIND_INDEX, want: 8'h00};
			{1'b0, 1'b0, 3'd1}: e = '{tx: 8'h60, rule: lhs_pkg::KIND_ROOM, want: 8'h00};
			{1'b0, 1'b0, 3'd2}: e = '{tx: 8'hD0, rule: lhs_pkg::KIND_ROOM, want: 8'h00};
			{1'b0, 1'b0, 3'd3}: e = '{tx: 8'hD4, rule: lhs_pkg::KIND_INDEX, want: 8'h00};
			{1'b0, 1'b1, 3'd0}: e = '{tx: 8'h60, rule: lhs_pkg::KIND_INDEX, want: 8'h00};
			{1'b0, 1'b1, 3'd1}: e = '{tx: 8'h60, rule: lhs_pkg::KIND_ONE, want: 8'hFD};
			{1'b1, 1'b0, 3'd0}: e = '{tx: 8'h01, rule: lhs_pkg::KIND_ONE, want: 8'h61};
			{1'b1, 1'b0, 3'd1}: e = '{tx: 8'h61, rule: lhs_pkg::KIND_ONE, want: 8'hD1};
			{1'b1, 1'b0, 3'd2}: e = '{tx: 8'hD1, rule: lhs_pkg::KIND_ONE, want: 8'h00};
			{1'b1, 1'b0, 3'd3}: e = '{tx: 8'h00, rule: lhs_pkg::KIND_ONE, want: 8'hFE};
			{1'b1, 1'b0, 3'd4}: e = '{tx: 8'hFE, rule: lhs_pkg::KIND_ONE, want: 8'hFE};
			{1'b1, 1'b1, 3'd0}: e = '{tx: 8'h75, rule: lhs_pkg::KIND_ONE, want: 8'h75};
			{1'b1, 1'b1, 3'd1}: e = '{tx: 8'h75, rule: lhs_pkg::KIND_ONE, want: 8'h00};
			{1'b1, 1'b1, 3'd2}: e = '{tx: 8'h76, rule: lhs_pkg::KIND_ONE, want: 8'hFD};
			default:            e = '{tx: 8'h00, rule: lhs_pkg::KIND_ONE, want: 8'h00};
		endcase
		return e;
	endfunction

	function automatic logic [lhs_pkg::STEP_W-1:0] link_steps(input logic g, input logic tp);
		case ({g, tp})
			2'b00:   return 3'd4;
			2'b01:   return 3'd2;
			2'b10:   return 3'd5;
			default: return 3'd3;
		endcase
	endfunction

	function automatic logic byte_fits(input link_step_t e,
			input logic [lhs_pkg::BYTE_W-1:0] b);
		case (e.rule)
			lhs_pkg::KIND_INDEX: return (b >= 8'h60 && b <= 8'h65) || b == 8'h6F;
			lhs_pkg::KIND_ROOM:  return b >= 8'hD0 && b <= 8'hD4;
			default:             return b == e.want;
		endcase
	endfunction

	function automatic logic [lhs_pkg::BYTE_W-1:0] fitting_byte(input link_step_t e);
		int n;
		case (e.rule)
			lhs_pkg::KIND_INDEX: begin
				n = $urandom_range(0, 6);
				return (n == 6) ? 8'h6F : 8'(8'h60 + n);
			end
			lhs_pkg::KIND_ROOM: return 8'(8'hD0 + $urandom_range(0, 4));
			default:            return e.want;
		endcase
	endfunction

	function automatic logic [lhs_pkg::COUNT_W-1:0] pick_limit();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) begin
			return 16'($urandom_range(16, 65535));
		end else if (p < 75) begin
			return 16'($urandom_range(2, 12));
		end else if (p < 83) begin
			return 16'd0;
		end else if (p < 91) begin
			return lhs_pkg::COUNT_MAX;
		end
		return 16'd1;
	endfunction

	task automatic step_link(input logic c, input logic [lhs_pkg::BYTE_W-1:0] b,
			output lhs_pkg::lhs_result_t r);
		link_step_t cur;
		logic       tp;
		if (c == lhs_pkg::CMD_START) begin
			gen_held     = gen_sel;
			link_phase   = lhs_pkg::PHASE_ROOM;
			link_step_no = '0;
			swaps        = '0;
			verdict      = lhs_pkg::STATUS_BUSY;
		end else if (link_phase != lhs_pkg::PHASE_IDLE && verdict == lhs_pkg::STATUS_BUSY) begin
			tp  = (link_phase == lhs_pkg::PHASE_TABLE);
			cur = link_step(gen_held, tp, link_step_no);
			if (link_step_no < link_steps(gen_held, tp) && byte_fits(cur, b))
				link_step_no++;
			if (swaps != lhs_pkg::COUNT_MAX)
				swaps++;
			if (swaps >= limit_sel) begin
				verdict = lhs_pkg::STATUS_NO_GAME;
			end else if (link_step_no >= link_steps(gen_held, tp)) begin
				if (link_phase == lhs_pkg::PHASE_ROOM) begin
					link_phase   = lhs_pkg::PHASE_TABLE;
					link_step_no = '0;
					swaps        = '0;
				end else begin
					verdict = lhs_pkg::STATUS_DONE;
				end
			end
		end
		if (link_phase == lhs_pkg::PHASE_IDLE) begin
			r = '{send_byte: 8'h00, status: lhs_pkg::STATUS_NO_GAME, phase_now: 1'b0};
		end else begin
			tp          = (link_phase == lhs_pkg::PHASE_TABLE);
			cur         = link_step(gen_held, tp, link_step_no);
			r.send_byte = (verdict == lhs_pkg::STATUS_BUSY) ? cur.tx : 8'h00;
			r.status    = verdict;
			r.phase_now = tp;
		end
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			if (req_ch.valid)
				req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_request(input logic c, input logic [lhs_pkg::BYTE_W-1:0] b,
			input logic typed, input lhs_pkg::lhs_result_t reply);
		lhs_pkg::lhs_result_t guess;
		pace();
		if (c == lhs_pkg::CMD_START
			|| (link_phase != lhs_pkg::PHASE_IDLE && verdict == lhs_pkg::STATUS_BUSY))
			requests_sent++;
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= c;
		req_ch.recv_byte <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		step_link(c, b, guess);
		due_replies.push_back(typed ? reply : guess);
	endtask

	task automatic write_reg(input logic idx, input logic [lhs_pkg::CFG_W-1:0] data);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == lhs_pkg::CFG_GEN_MODE)
			gen_sel = data[0];
		else
			limit_sel = data;
	endtask

	task automatic run_handshake();
		int                         n;
		logic [lhs_pkg::BYTE_W-1:0] b;
		link_step_t                 cur;
		send_request(lhs_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'b0, '0);
		n = 0;
		while (n < 60 && link_phase != lhs_pkg::PHASE_IDLE
			&& verdict == lhs_pkg::STATUS_BUSY) begin
			if ($urandom_range(0, 99) < 3) begin
				send_request(lhs_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'b0, '0);
			end else begin
				cur = link_step(gen_held, link_phase == lhs_pkg::PHASE_TABLE, link_step_no);
				b = ($urandom_range(0, 99) < 80) ? fitting_byte(cur)
					: 8'($urandom_range(0, 255));
				send_request(lhs_pkg::CMD_EXCHANGE, b, 1'b0, '0);
			end
			n++;
		end
		repeat ($urandom_range(0, 2))
			send_request(lhs_pkg::CMD_EXCHANGE, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic add_item(input logic c, input logic [lhs_pkg::BYTE_W-1:0] b);
		plan.push_back('{is_reg: 1'b0, idx: lhs_pkg::CFG_GEN_MODE, data: '0, cmd: c, rx: b,
			typed: 1'b0, reply: '0});
	endtask

	task automatic add_typed(input logic c, input logic [lhs_pkg::BYTE_W-1:0] b,
			input logic [lhs_pkg::BYTE_W-1:0] tx, input logic [1:0] st, input logic ph);
		plan.push_back('{is_reg: 1'b0, idx: lhs_pkg::CFG_GEN_MODE, data: '0, cmd: c, rx: b,
			typed: 1'b1, reply: '{send_byte: tx, status: st, phase_now: ph}});
	endtask

	task automatic add_reg(input logic idx, input logic [lhs_pkg::CFG_W-1:0] data);
		plan.push_back('{is_reg: 1'b1, idx: idx, data: data, cmd: lhs_pkg::CMD_START, rx: '0,
			typed: 1'b0, reply: '0});
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_kind_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(40, 250);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_NONE:  rsp_ch.ready <= 1'b1;
			STALL_LIGHT: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
			STALL_BEAT:  rsp_ch.ready <= (stall_tick % 4 != 3);
			default:     rsp_ch.ready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin
		lhs_pkg::lhs_result_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_replies.size() == 0) begin
				flag_mismatch("result with nothing due", int'(rsp_ch.send_byte), 0);
			end else begin
				w = due_replies.pop_front();
				if (rsp_ch.send_byte !== w.send_byte)
					flag_mismatch("send_byte", int'(rsp_ch.send_byte), int'(w.send_byte));
				if (rsp_ch.status !== w.status)
					flag_mismatch("status", int'(rsp_ch.status), int'(w.status));
				if (rsp_ch.phase_now !== w.phase_now)
					flag_mismatch("phase_now", int'(rsp_ch.phase_now), int'(w.phase_now));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int pick;
		int last_pause;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = lhs_pkg::CFG_GEN_MODE;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = lhs_pkg::CMD_START;
		req_ch.recv_byte = '0;
		rsp_ch.ready     = 1'b0;
		stall_mode       = STALL_NONE;
		stall_left       = 0;
		stall_tick       = 0;
		mismatches       = 0;
		requests_sent    = 0;
		burst_left       = 0;
		gen_sel          = 1'b0;
		limit_sel        = lhs_pkg::SWAP_LIMIT_RESET;
		gen_held         = 1'b0;
		link_phase       = lhs_pkg::PHASE_IDLE;
		link_step_no     = '0;
		swaps            = '0;
		verdict          = lhs_pkg::STATUS_BUSY;

		// An exchange before any start is ignored.
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'hFF, 8'h00, lhs_pkg::STATUS_NO_GAME, 1'b0);
		add_typed(lhs_pkg::CMD_START, 8'h00, 8'h01, lhs_pkg::STATUS_BUSY, 1'b0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h60);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'hD4);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'hD0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h6F);
		// The last step of the table phase meets the limit; the limit wins and the outcome is no game.
		add_reg(lhs_pkg::CFG_SWAP_LIMIT, 16'd2);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h65);
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'hFD, 8'h00, lhs_pkg::STATUS_NO_GAME, 1'b1);
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'hFF, 8'h00, lhs_pkg::STATUS_NO_GAME, 1'b1);
		add_reg(lhs_pkg::CFG_GEN_MODE, 16'd1);
		add_reg(lhs_pkg::CFG_SWAP_LIMIT, lhs_pkg::COUNT_MAX);
		add_typed(lhs_pkg::CMD_START, 8'hFF, 8'h01, lhs_pkg::STATUS_BUSY, 1'b0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h61);
		// A change of generation mid-handshake waits for the next start.
		add_reg(lhs_pkg::CFG_GEN_MODE, 16'd0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'hD1);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'hFE);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'hFE);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h75);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'hFD, 8'h00, lhs_pkg::STATUS_DONE, 1'b1);
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'h00, 8'h00, lhs_pkg::STATUS_DONE, 1'b1);
		add_typed(lhs_pkg::CMD_START, 8'h00, 8'h01, lhs_pkg::STATUS_BUSY, 1'b0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_typed(lhs_pkg::CMD_START, 8'h80, 8'h01, lhs_pkg::STATUS_BUSY, 1'b0);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_item(lhs_pkg::CMD_EXCHANGE, 8'h00);
		add_reg(lhs_pkg::CFG_SWAP_LIMIT, 16'd0);
		add_typed(lhs_pkg::CMD_EXCHANGE, 8'h60, 8'h00, lhs_pkg::STATUS_NO_GAME, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_request(plan[i].cmd, plan[i].rx, plan[i].typed, plan[i].reply);
		end

		write_reg(lhs_pkg::CFG_SWAP_LIMIT, pick_limit());
		last_pause = requests_sent;
		while (requests_sent < REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				if ($urandom_range(0, 1))
					write_reg(lhs_pkg::CFG_GEN_MODE, 16'($urandom_range(0, 65535)));
				else
					write_reg(lhs_pkg::CFG_SWAP_LIMIT, pick_limit());
			end else if (pick < 12) begin
				repeat ($urandom_range(1, 4))
					send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'b0, '0);
			end else begin
				run_handshake();
			end
			// Hold every request back now and then until all results are in.
			if (requests_sent - last_pause >= 150) begin
				settle();
				last_pause = requests_sent;
			end
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
